// File: design/cds_pkg.sv
package cds_pkg;

    localparam int YEAR_BITS    = 14;
    localparam int AMOUNT_BITS  = 16;
    localparam int DIV_BITS     = (YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS;
    localparam int REM_BITS     = 9;
    localparam int DAYS_BITS    = AMOUNT_BITS + 3;

    // reciprocals for the constant divides; exact for any 16-bit dividend
    localparam int RECIP_BITS        = 17;
    localparam int PROD_BITS         = DIV_BITS + RECIP_BITS;
    localparam int RECIP_MONTH_SHIFT = 19;
    localparam int RECIP_YEAR_SHIFT  = 25;
    localparam logic [RECIP_BITS-1:0] RECIP_MONTH = 17'd43691;
    localparam logic [RECIP_BITS-1:0] RECIP_YEAR  = 17'd83887;

    localparam logic [2:0] KIND_DAYS    = 3'd0;
    localparam logic [2:0] KIND_WEEKS   = 3'd1;
    localparam logic [2:0] KIND_MONTHS  = 3'd2;
    localparam logic [2:0] KIND_YEARS   = 3'd3;
    localparam logic [2:0] KIND_YDIRECT = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    localparam logic [REM_BITS:0]   DIVISOR_YEAR  = 10'd400;
    localparam logic [REM_BITS:0]   DIVISOR_MONTH = 10'd12;
    localparam logic [REM_BITS-1:0] YMOD_MAX      = 9'd399;

    typedef struct packed {
        logic load_in;
        logic div_load;
        logic div_amt;
        logic ym_load;
        logic set_invalid;
        logic set_uf;
        logic days_init;
        logic days_step;
        logic mon_init;
        logic mon_step;
        logic mon_fin;
        logic ysub;
        logic clamp;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic       invalid;
        logic [2:0] kind;
        logic       day_fin;
        logic       mon_uf;
        logic       mon_sticky;
        logic       y_uf;
    } stat_t;

    // leap test from the year taken modulo 400
    function automatic logic is_leap(input logic [REM_BITS-1:0] ym);
        logic century;
        century = (ym == 9'd100) || (ym == 9'd200) || (ym == 9'd300);
        return (ym == '0) || (!century && (ym[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: design/cds_div.sv
module cds_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           sel_month,
    input  logic [cds_pkg::DIV_BITS-1:0]   dividend,
    output logic                           busy,
    output logic [cds_pkg::DIV_BITS-1:0]   quot,
    output logic [cds_pkg::REM_BITS-1:0]   rem
);
    import cds_pkg::*;

    logic [DIV_BITS-1:0]   dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]   q_reg, q_next;
    logic [REM_BITS-1:0]   r_reg, r_next;
    logic                  busy_reg, busy_next;
    logic                  step_reg, step_next;
    logic                  sel_reg, sel_next;
    logic [REM_BITS:0]     divisor;
    logic [RECIP_BITS-1:0] recip;
    logic [PROD_BITS-1:0]  prod;
    logic [DIV_BITS-1:0]   q_est, back;

    // quotient by reciprocal multiply in the first step, remainder by
    // multiply-back and subtract in the second
    always_comb
    begin
        divisor   = sel_reg ? DIVISOR_MONTH : DIVISOR_YEAR;
        recip     = sel_reg ? RECIP_MONTH : RECIP_YEAR;
        prod      = PROD_BITS'(dvd_reg) * PROD_BITS'(recip);
        q_est     = sel_reg ? DIV_BITS'(prod >> RECIP_MONTH_SHIFT)
                            : DIV_BITS'(prod >> RECIP_YEAR_SHIFT);
        back      = q_reg * DIV_BITS'(divisor);
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        sel_next  = sel_reg;
        if (load)
        begin
            dvd_next  = dividend;
            sel_next  = sel_month;
            busy_next = 1'b1;
            step_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                q_next    = q_est;
                step_next = 1'b1;
            end
            else
            begin
                r_next    = REM_BITS'(dvd_reg - back);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        sel_reg <= sel_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// File: design/cds_datapath.sv
module cds_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cds_pkg::cmd_t                     cmd,
    input  logic [2:0]                        kind,
    input  logic [4:0]                        day_in,
    input  logic [3:0]                        month_in,
    input  logic [cds_pkg::YEAR_BITS-1:0]     year_in,
    input  logic [cds_pkg::AMOUNT_BITS-1:0]   amount,
    output cds_pkg::stat_t                    stat,
    output logic [4:0]                        day_out,
    output logic [3:0]                        month_out,
    output logic [cds_pkg::YEAR_BITS-1:0]     year_out,
    output logic [1:0]                        status,
    output logic                              done
);
    import cds_pkg::*;

    logic [2:0]             kind_reg, kind_next;
    logic [AMOUNT_BITS-1:0] amt_reg, amt_next;
    logic [4:0]             d_reg, d_next;
    logic [3:0]             m_reg, m_next;
    logic [YEAR_BITS-1:0]   y_reg, y_next;
    logic [REM_BITS-1:0]    ym_reg, ym_next;
    logic [DAYS_BITS-1:0]   r_reg, r_next;
    logic [AMOUNT_BITS-1:0] ry_reg, ry_next;
    logic [3:0]             rm_reg, rm_next;
    logic [1:0]             st_reg, st_next;
    logic [4:0]             day_out_reg, day_out_next;
    logic [3:0]             month_out_reg, month_out_next;
    logic [YEAR_BITS-1:0]   year_out_reg, year_out_next;
    logic [1:0]             status_reg, status_next;
    logic                   done_reg;

    logic                   div_busy;
    logic [DIV_BITS-1:0]    div_quot, div_dividend;
    logic [REM_BITS-1:0]    div_rem;

    logic                   leap, jump, r_ge_d, at_floor, borrow;
    logic [4:0]             cur_len, prev_len;
    logic [3:0]             prev_m;
    logic [REM_BITS-1:0]    ym_dec;
    logic [8:0]             year_len;
    logic [DIV_BITS-1:0]    ry_w, y_w, amt_w, y_fin;
    logic [DAYS_BITS-1:0]   amt_days;

    assign div_dividend = cmd.div_amt ? DIV_BITS'(amt_reg) : DIV_BITS'(y_reg);

    cds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .sel_month (cmd.div_amt),
        .dividend  (div_dividend),
        .busy      (div_busy),
        .quot      (div_quot),
        .rem       (div_rem)
    );

    always_comb
    begin
        leap     = is_leap(ym_reg);
        cur_len  = month_len(m_reg, leap);
        prev_m   = (m_reg == 4'd1) ? 4'd12 : m_reg - 4'd1;
        prev_len = month_len(prev_m, leap);
        ym_dec   = (ym_reg == '0) ? YMOD_MAX : ym_reg - 1'b1;
        year_len = leap ? 9'd366 : 9'd365;
        jump     = (m_reg == 4'd12) && (d_reg == 5'd31) && (y_reg != '0)
                   && (r_reg >= DAYS_BITS'(year_len));
        r_ge_d   = r_reg >= DAYS_BITS'(d_reg);
        at_floor = (m_reg == 4'd1) && (y_reg == '0);
        ry_w     = DIV_BITS'(ry_reg);
        y_w      = DIV_BITS'(y_reg);
        amt_w    = DIV_BITS'(amt_reg);
        borrow   = rm_reg >= m_reg;
        y_fin    = y_w - ry_w - DIV_BITS'(borrow);
        amt_days = (DAYS_BITS'(amt_reg) << 3) - DAYS_BITS'(amt_reg);

        stat.div_busy   = div_busy;
        stat.invalid    = (m_reg == 4'd0) || (m_reg > 4'd12) || (d_reg == 5'd0)
                          || (d_reg > cur_len);
        stat.kind       = kind_reg;
        stat.day_fin    = !jump && (!r_ge_d || at_floor);
        stat.mon_uf     = (ry_w > y_w) || ((ry_w == y_w) && borrow);
        stat.mon_sticky = ((ry_reg != '0) || (rm_reg != 4'd0)) && (d_reg > 5'd28);
        stat.y_uf       = amt_w > y_w;
    end

    always_comb
    begin
        kind_next      = kind_reg;
        amt_next       = amt_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        y_next         = y_reg;
        ym_next        = ym_reg;
        r_next         = r_reg;
        ry_next        = ry_reg;
        rm_next        = rm_reg;
        st_next        = st_reg;
        day_out_next   = day_out_reg;
        month_out_next = month_out_reg;
        year_out_next  = year_out_reg;
        status_next    = status_reg;

        if (cmd.load_in)
        begin
            kind_next = kind;
            amt_next  = amount;
            d_next    = day_in;
            m_next    = month_in;
            y_next    = year_in;
            st_next   = ST_OK;
        end
        else if (cmd.ym_load)
        begin
            ym_next = div_rem;
        end
        else if (cmd.set_invalid)
        begin
            st_next = ST_INVALID;
        end
        else if (cmd.set_uf)
        begin
            st_next = ST_UNDERFLOW;
        end
        else if (cmd.days_init)
        begin
            r_next = (kind_reg == KIND_WEEKS) ? amt_days : DAYS_BITS'(amt_reg);
        end
        else if (cmd.days_step)
        begin
            if (jump)
            begin
                // drop one whole year from 31 Dec to 31 Dec
                y_next  = y_reg - 1'b1;
                ym_next = ym_dec;
                r_next  = r_reg - DAYS_BITS'(year_len);
            end
            else if (r_ge_d)
            begin
                if (at_floor)
                begin
                    st_next = ST_UNDERFLOW;
                end
                else
                begin
                    r_next = r_reg - DAYS_BITS'(d_reg);
                    m_next = prev_m;
                    d_next = prev_len;
                    if (m_reg == 4'd1)
                    begin
                        y_next  = y_reg - 1'b1;
                        ym_next = ym_dec;
                    end
                end
            end
            else
            begin
                d_next = d_reg - r_reg[4:0];
            end
        end
        else if (cmd.mon_init)
        begin
            if (kind_reg == KIND_YEARS)
            begin
                ry_next = amt_reg;
                rm_next = 4'd0;
            end
            else
            begin
                ry_next = div_quot[AMOUNT_BITS-1:0];
                rm_next = div_rem[3:0];
            end
        end
        else if (cmd.mon_step)
        begin
            if (rm_reg != 4'd0)
            begin
                rm_next = rm_reg - 4'd1;
            end
            else
            begin
                ry_next = ry_reg - 1'b1;
                rm_next = 4'd11;
            end
            m_next = prev_m;
            if (d_reg > prev_len)
            begin
                d_next = prev_len;
            end
            if (m_reg == 4'd1)
            begin
                y_next  = y_reg - 1'b1;
                ym_next = ym_dec;
            end
        end
        else if (cmd.mon_fin)
        begin
            y_next = y_fin[YEAR_BITS-1:0];
            m_next = borrow ? m_reg + 4'd12 - rm_reg : m_reg - rm_reg;
        end
        else if (cmd.ysub)
        begin
            y_next = y_reg - amt_reg[YEAR_BITS-1:0];
        end
        else if (cmd.clamp)
        begin
            if (d_reg > cur_len)
            begin
                d_next = cur_len;
            end
        end
        else if (cmd.emit)
        begin
            status_next = st_reg;
            if (st_reg == ST_UNDERFLOW)
            begin
                day_out_next   = 5'd1;
                month_out_next = 4'd1;
                year_out_next  = '0;
            end
            else
            begin
                day_out_next   = d_reg;
                month_out_next = m_reg;
                year_out_next  = y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        amt_reg       <= amt_next;
        d_reg         <= d_next;
        m_reg         <= m_next;
        y_reg         <= y_next;
        ym_reg        <= ym_next;
        r_reg         <= r_next;
        ry_reg        <= ry_next;
        rm_reg        <= rm_next;
        st_reg        <= st_next;
        day_out_reg   <= day_out_next;
        month_out_reg <= month_out_next;
        year_out_reg  <= year_out_next;
        status_reg    <= status_next;
    end

    assign day_out   = day_out_reg;
    assign month_out = month_out_reg;
    assign year_out  = year_out_reg;
    assign status    = status_reg;
    assign done      = done_reg;

endmodule

// File: design/cds_ctrl.sv
module cds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cds_pkg::stat_t  stat,
    output cds_pkg::cmd_t   cmd,
    output logic            busy
);
    import cds_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_YMOD_GO = 4'd1;
    localparam logic [3:0] S_YMOD    = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_DAYS    = 4'd4;
    localparam logic [3:0] S_ADIV    = 4'd5;
    localparam logic [3:0] S_MCHK    = 4'd6;
    localparam logic [3:0] S_MSTEP   = 4'd7;
    localparam logic [3:0] S_YSUB    = 4'd8;
    localparam logic [3:0] S_YGO     = 4'd9;
    localparam logic [3:0] S_YMOD2   = 4'd10;
    localparam logic [3:0] S_CLAMP   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_YMOD_GO;
                end
            end
            S_YMOD_GO:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_YMOD;
            end
            S_YMOD:
            begin
                if (!stat.div_busy)
                begin
                    cmd.ym_load = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.invalid)
                begin
                    cmd.set_invalid = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    unique case (stat.kind) inside
                        KIND_DAYS, KIND_WEEKS:
                        begin
                            cmd.days_init = 1'b1;
                            state_next    = S_DAYS;
                        end
                        KIND_MONTHS:
                        begin
                            cmd.div_load = 1'b1;
                            cmd.div_amt  = 1'b1;
                            state_next   = S_ADIV;
                        end
                        KIND_YEARS:
                        begin
                            cmd.mon_init = 1'b1;
                            state_next   = S_MCHK;
                        end
                        KIND_YDIRECT:
                        begin
                            state_next = S_YSUB;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DAYS:
            begin
                cmd.days_step = 1'b1;
                if (stat.day_fin)
                begin
                    state_next = S_DONE;
                end
            end
            S_ADIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mon_init = 1'b1;
                    state_next   = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (stat.mon_uf)
                begin
                    cmd.set_uf = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MSTEP;
                end
            end
            S_MSTEP:
            begin
                if (stat.mon_sticky)
                begin
                    cmd.mon_step = 1'b1;
                end
                else
                begin
                    cmd.mon_fin = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_YSUB:
            begin
                if (stat.y_uf)
                begin
                    cmd.set_uf = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ysub   = 1'b1;
                    state_next = S_YGO;
                end
            end
            S_YGO:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_YMOD2;
            end
            S_YMOD2:
            begin
                if (!stat.div_busy)
                begin
                    cmd.ym_load = 1'b1;
                    state_next  = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: design/calendar_date_subtract_unit.sv
// Gregorian date subtraction unit.
//
// Command channel: assert start with kind, day_in, month_in, year_in and
// amount; the transfer happens at the rising edge where start is high and
// busy is low. busy stays high until the result is out; hold new commands.
// Result channel: done pulses for one cycle with day_out, month_out,
// year_out and status; the receiver cannot stall, so capture it then.
// The output registers keep the last result until the next one.
//
// Sequence, from the command transfer to the done pulse:
//   setup: the year modulo 400 (reciprocal multiply), then the check
//     state; an invalid date or an unused kind goes straight to done
//   days, weeks: one step per month crossed in partial years and one per
//     whole year dropped
//   months stepwise: divide by 12, then one step per month stepped while
//     the day is above 28, then the month and year fix-up; underflow ends
//     at the check; years stepwise: the same sticky month steps, no divide
//   years direct: subtract, year modulo 400 again, clamp the day
// One command is in flight at a time; the next may transfer while done is
// high. The day-step loop sets the worst case.
// Reset returns the controller to idle; no result is pending after reset.
module calendar_date_subtract_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        kind,
    input  logic [4:0]                        day_in,
    input  logic [3:0]                        month_in,
    input  logic [cds_pkg::YEAR_BITS-1:0]     year_in,
    input  logic [cds_pkg::AMOUNT_BITS-1:0]   amount,
    output logic                              done,
    output logic [4:0]                        day_out,
    output logic [3:0]                        month_out,
    output logic [cds_pkg::YEAR_BITS-1:0]     year_out,
    output logic [1:0]                        status
);
    import cds_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decides the step order, waits on the divider, emits
    cds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: date registers, remaining counts, divider, result registers
    cds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (kind),
        .day_in    (day_in),
        .month_in  (month_in),
        .year_in   (year_in),
        .amount    (amount),
        .stat      (stat),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .status    (status),
        .done      (done)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("done without a command in flight");

    a_uf_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_UNDERFLOW) |->
            (day_out == 5'd1) && (month_out == 4'd1) && (year_out == '0))
        else $error("underflow result not saturated to 1/1/0");

    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OK) |->
            (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out != 5'd0))
        else $error("ok result carries a malformed date");
`endif

endmodule

// File: dv/calendar_date_subtract_checker.sv
module calendar_date_subtract_checker
    import cds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [2:0]             kind,
    input  logic [4:0]             day_in,
    input  logic [3:0]             month_in,
    input  logic [YEAR_BITS-1:0]   year_in,
    input  logic [AMOUNT_BITS-1:0] amount,
    input  logic                   done,
    input  logic [4:0]             day_out,
    input  logic [3:0]             month_out,
    input  logic [YEAR_BITS-1:0]   year_out,
    input  logic [1:0]             status,
    output int                     mismatch_count,
    output int                     dates_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [4:0]           day;
        logic [3:0]           month;
        logic [YEAR_BITS-1:0] year;
        logic [1:0]           status;
    } date_result_t;

    date_result_t due_dates[$];
    date_result_t oldest_due;

    function automatic bit leap_year(input longint unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic longint unsigned month_days(input longint unsigned m,
                                                   input longint unsigned y);
        case (m)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // days from 1/1/0 up to 1/1/y
    function automatic longint unsigned year_start(input longint unsigned y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic longint unsigned day_serial(input longint unsigned d,
                                                   input longint unsigned m,
                                                   input longint unsigned y);
        longint unsigned n;
        n = year_start(y);
        for (longint unsigned k = 1; k < m; k++)
            n += month_days(k, y);
        return n + d - 1;
    endfunction

    function automatic date_result_t date_of_serial(input longint unsigned n);
        longint unsigned yr;
        longint unsigned mo;
        longint unsigned rest;
        date_result_t    r;
        yr = n / 366;
        mo = 1;
        while (year_start(yr + 1) <= n)
            yr++;
        rest = n - year_start(yr);
        while (mo < 12 && rest >= month_days(mo, yr)) begin
            rest -= month_days(mo, yr);
            mo++;
        end
        r.day    = 5'(rest + 1);
        r.month  = 4'(mo);
        r.year   = YEAR_BITS'(yr);
        r.status = ST_OK;
        return r;
    endfunction

    function automatic date_result_t earlier_date(input logic [2:0]             k,
                                                  input logic [4:0]             d,
                                                  input logic [3:0]             m,
                                                  input logic [YEAR_BITS-1:0]   y,
                                                  input logic [AMOUNT_BITS-1:0] a);
        longint unsigned dd;
        longint unsigned mm;
        longint unsigned yy;
        longint unsigned amt;
        longint unsigned n;
        longint unsigned sub;
        longint unsigned idx;
        longint unsigned steps;
        longint unsigned lim;
        logic [1:0]      st;
        date_result_t    r;
        dd  = d;
        mm  = m;
        yy  = y;
        amt = a;
        st  = ST_OK;
        if (mm < 1 || mm > 12 || dd == 0 || dd > month_days(mm, yy)) begin
            st = ST_INVALID;
        end else begin
            case (k)
                KIND_DAYS, KIND_WEEKS:
                begin
                    n   = day_serial(dd, mm, yy);
                    sub = (k == KIND_WEEKS) ? amt * 7 : amt;
                    if (sub > n) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        r  = date_of_serial(n - sub);
                        dd = r.day;
                        mm = r.month;
                        yy = r.year;
                    end
                end
                KIND_MONTHS, KIND_YEARS:
                begin
                    idx   = yy * 12 + (mm - 1);
                    steps = (k == KIND_YEARS) ? amt * 12 : amt;
                    if (steps > idx) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        // clamp is sticky; at 28 or below nothing more changes
                        while (steps > 0 && dd > 28) begin
                            idx--;
                            steps--;
                            lim = month_days(idx % 12 + 1, idx / 12);
                            if (dd > lim)
                                dd = lim;
                        end
                        idx -= steps;
                        yy = idx / 12;
                        mm = idx % 12 + 1;
                    end
                end
                KIND_YDIRECT:
                begin
                    if (amt > yy) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        yy -= amt;
                        lim = month_days(mm, yy);
                        if (dd > lim)
                            dd = lim;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (st == ST_UNDERFLOW) begin
            dd = 1;
            mm = 1;
            yy = 0;
        end
        r.day    = 5'(dd);
        r.month  = 4'(mm);
        r.year   = YEAR_BITS'(yy);
        r.status = st;
        return r;
    endfunction

    task automatic field_check(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        dates_pending  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done) begin
                if (due_dates.size() == 0) begin
                    $display("%0t: result %0d/%0d/%0d status %0d with no command outstanding",
                             $time, day_out, month_out, year_out, status);
                    mismatch_count++;
                end else begin
                    oldest_due = due_dates.pop_front();
                    field_check("day_out", oldest_due.day, day_out);
                    field_check("month_out", oldest_due.month, month_out);
                    field_check("year_out", oldest_due.year, year_out);
                    field_check("status", oldest_due.status, status);
                end
            end
            if (start && !busy)
                due_dates.push_back(earlier_date(kind, day_in, month_in, year_in, amount));
            dates_pending = due_dates.size();
        end
    end

endmodule

// File: dv/tb_calendar_date_subtract_unit.sv
module tb_calendar_date_subtract_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cds_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 2;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASES        = 4;
    // Worst case is a full-range week count. Reckon every command at that
    // worst-case cost plus the longest idle gap, then take it several times
    // over.
    localparam longint CYCLE_LIMIT = 12_000_000;
    // The block holds no result back once the last one is out, so a short
    // drain is enough to catch a stray strobe.
    localparam int DRAIN_CYCLES  = 64;

    // Kinds beyond the five defined ones subtract nothing.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic [YEAR_BITS-1:0]   MAX_YEAR   = '1;
    localparam logic [AMOUNT_BITS-1:0] MAX_AMOUNT = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [2:0]             kind;
    logic [4:0]             day_in;
    logic [3:0]             month_in;
    logic [YEAR_BITS-1:0]   year_in;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   done;
    logic [4:0]             day_out;
    logic [3:0]             month_out;
    logic [YEAR_BITS-1:0]   year_out;
    logic [1:0]             status;

    int     mismatch_count;
    int     dates_pending;
    int     idle_pct;
    longint cycle_count;

    calendar_date_subtract_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .day_in    (day_in),
        .month_in  (month_in),
        .year_in   (year_in),
        .amount    (amount),
        .done      (done),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .status    (status)
    );

    // Watch both channels, predict each result and compare.
    calendar_date_subtract_checker date_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .day_in         (day_in),
        .month_in       (month_in),
        .year_in        (year_in),
        .amount         (amount),
        .done           (done),
        .day_out        (day_out),
        .month_out      (month_out),
        .year_out       (year_out),
        .status         (status),
        .mismatch_count (mismatch_count),
        .dates_pending  (dates_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Issue one command and hold it until the transfer. Start stays high
    // straight into the next command when there is no idle gap, so the
    // block sees a command waiting the moment busy drops. With idling on,
    // now and then drop start for a random gap; half the time first wait out
    // the busy period so the gap lands after the block has gone idle.
    task automatic send_cmd(input logic [2:0]             k,
                            input logic [4:0]             d,
                            input logic [3:0]             m,
                            input logic [YEAR_BITS-1:0]   y,
                            input logic [AMOUNT_BITS-1:0] a);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            if ($urandom_range(1) == 1)
                while (busy)
                    @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        day_in   <= d;
        month_in <= m;
        year_in  <= y;
        amount   <= a;
        // Advance until an edge samples start high with busy low.
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        logic [2:0]             k;
        logic [4:0]             d;
        logic [3:0]             m;
        logic [YEAR_BITS-1:0]   y;
        int                     amt_w;
        int                     pick;

        // Hold every input at a known value from time zero.
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_DAYS;
        day_in      = 5'd1;
        month_in    = 4'd1;
        year_in     = '0;
        amount      = '0;
        idle_pct    = 0;
        cycle_count = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every kind, leap and century edges,
        // sticky clamp, saturation, invalid dates and the spare kinds.
        send_cmd(KIND_DAYS,    5'd31, 4'd12, MAX_YEAR,  '0);
        send_cmd(KIND_DAYS,    5'd1,  4'd1,  14'd0,     16'd1);
        send_cmd(KIND_DAYS,    5'd1,  4'd3,  14'd2000,  16'd1);
        send_cmd(KIND_DAYS,    5'd1,  4'd3,  14'd1900,  16'd1);
        send_cmd(KIND_DAYS,    5'd1,  4'd1,  14'd1,     16'd366);
        send_cmd(KIND_DAYS,    5'd31, 4'd12, MAX_YEAR,  MAX_AMOUNT);
        send_cmd(KIND_WEEKS,   5'd31, 4'd12, MAX_YEAR,  MAX_AMOUNT);
        send_cmd(KIND_WEEKS,   5'd7,  4'd1,  14'd0,     16'd1);
        send_cmd(KIND_MONTHS,  5'd31, 4'd3,  14'd2001,  16'd1);
        send_cmd(KIND_MONTHS,  5'd31, 4'd5,  14'd2000,  16'd3);
        send_cmd(KIND_MONTHS,  5'd31, 4'd1,  14'd0,     16'd1);
        send_cmd(KIND_MONTHS,  5'd15, 4'd6,  MAX_YEAR,  MAX_AMOUNT);
        send_cmd(KIND_YEARS,   5'd29, 4'd2,  14'd2000,  16'd1);
        send_cmd(KIND_YEARS,   5'd31, 4'd12, MAX_YEAR,  16'd16383);
        send_cmd(KIND_YEARS,   5'd31, 4'd12, MAX_YEAR,  16'd16384);
        send_cmd(KIND_YDIRECT, 5'd29, 4'd2,  14'd2000,  16'd100);
        send_cmd(KIND_YDIRECT, 5'd29, 4'd2,  14'd2000,  16'd400);
        send_cmd(KIND_YDIRECT, 5'd10, 4'd10, 14'd500,   16'd501);
        send_cmd(KIND_YDIRECT, 5'd1,  4'd1,  14'd0,     MAX_AMOUNT);
        send_cmd(KIND_DAYS,    5'd1,  4'd0,  14'd2000,  16'd5);
        send_cmd(KIND_DAYS,    5'd1,  4'd13, 14'd2000,  16'd5);
        send_cmd(KIND_MONTHS,  5'd31, 4'd15, MAX_YEAR,  16'd5);
        send_cmd(KIND_WEEKS,   5'd0,  4'd6,  14'd2000,  16'd5);
        send_cmd(KIND_DAYS,    5'd31, 4'd4,  14'd2000,  16'd5);
        send_cmd(KIND_YDIRECT, 5'd29, 4'd2,  14'd1900,  16'd1);
        send_cmd(KIND_SPARE_FIRST, 5'd15, 4'd8, 14'd1999, 16'd77);
        send_cmd(KIND_SPARE_LAST,  5'd31, 4'd11, 14'd1999, MAX_AMOUNT);

        // Random part, in phases: no idling, heavy sender idling, light
        // sender idling, then no idling again. The result side has no
        // stall to apply.
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p == 1) ? 53 : (p == 2) ? 15 : 0;
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                // Mostly the five real kinds, now and then a spare one.
                if ($urandom_range(99) < 8)
                    k = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
                else
                    k = 3'($urandom_range(KIND_YDIRECT, KIND_DAYS));

                if ($urandom_range(99) < 10) begin
                    // Noise: any bit pattern for the date.
                    d = 5'($urandom_range(31));
                    m = 4'($urandom_range(15));
                    y = YEAR_BITS'($urandom);
                end else begin
                    // Well-formed date, biased to month ends and to year
                    // ranges where leap rules and saturation bite.
                    m = 4'($urandom_range(12, 1));
                    d = ($urandom_range(99) < 40) ? 5'($urandom_range(28, 1))
                                                  : 5'($urandom_range(31, 28));
                    pick = $urandom_range(9);
                    if (pick < 4)
                        y = YEAR_BITS'($urandom);
                    else if (pick < 6)
                        y = YEAR_BITS'($urandom_range(60));
                    else if (pick < 8)
                        y = YEAR_BITS'($urandom_range(163) * 100 + $urandom_range(4));
                    else
                        y = MAX_YEAR - YEAR_BITS'($urandom_range(60));
                end

                // Keep day and week counts mostly small: the block walks
                // them a year at a time. Month and year steps are cheap.
                pick = $urandom_range(99);
                case (k)
                    KIND_DAYS:
                    begin
                        if (pick < 55)      amt_w = $urandom_range(400);
                        else if (pick < 80) amt_w = $urandom_range(5000);
                        else if (pick < 92) amt_w = $urandom_range(MAX_AMOUNT);
                        else                amt_w = y * 365 + $urandom_range(400);
                    end
                    KIND_WEEKS:
                    begin
                        if (pick < 60)      amt_w = $urandom_range(60);
                        else if (pick < 85) amt_w = $urandom_range(800);
                        else if (pick < 95) amt_w = $urandom_range(MAX_AMOUNT);
                        else                amt_w = MAX_AMOUNT;
                    end
                    KIND_MONTHS:
                    begin
                        if (pick < 40)      amt_w = $urandom_range(40);
                        else if (pick < 70) amt_w = $urandom_range(2000);
                        else if (pick < 90) amt_w = $urandom_range(MAX_AMOUNT);
                        else                amt_w = y * 12 + m - 1 + $urandom_range(1);
                    end
                    KIND_YEARS, KIND_YDIRECT:
                    begin
                        if (pick < 40)      amt_w = $urandom_range(20);
                        else if (pick < 70) amt_w = $urandom_range(y);
                        else if (pick < 90) amt_w = $urandom_range(MAX_AMOUNT);
                        else                amt_w = y + $urandom_range(1);
                    end
                    default:
                    begin
                        amt_w = $urandom_range(MAX_AMOUNT);
                    end
                endcase
                if (amt_w < 0)
                    amt_w = 0;
                if (amt_w > MAX_AMOUNT)
                    amt_w = MAX_AMOUNT;

                send_cmd(k, d, m, y, AMOUNT_BITS'(amt_w));
            end
        end

        // Drop start, let the checker register the last transfer, then
        // wait for every predicted result and drain.
        start <= 1'b0;
        @(posedge clk);
        while (dates_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
